FILE: rtl/core/bgi_pkg.sv
`default_nettype none
package bgi_pkg;

    typedef enum logic [1:0] {
        OP_WR_X   = 2'd0,
        OP_WR_Y   = 2'd1,
        OP_WR_Z   = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EQUAL  = 2'd1,
        ST_SAT    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_X_COUNT = 2'd0,
        CFG_Y_COUNT = 2'd1
    } t_cfg_idx;

    localparam int CFG_WIDTH = 7;

    typedef enum logic [4:0] {
        S_IDLE,
        S_XLO_RD,
        S_XLO_CHK,
        S_XHI_CHK,
        S_XBS_RD,
        S_XBS_CHK,
        S_YLO_RD,
        S_YLO_CHK,
        S_YHI_CHK,
        S_YBS_RD,
        S_YBS_CHK,
        S_XE0_RD,
        S_XE1_RD,
        S_YE0_RD,
        S_YE1_RD,
        S_Z_RD,
        S_Z_CAP,
        S_EQ_CHK,
        S_LIN_MUL,
        S_LIN_GO,
        S_LIN_DIV,
        S_LIN_END,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/core/bgi_ram.sv
`default_nettype none
module bgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/bgi_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, round half away from zero.
module bgi_div #(
    parameter int NW = 128,
    parameter int DW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_n;
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_fin;
    logic [DW:0]   n_sh;
    logic [DW:0]   n_diff;
    logic [DW:0]   n_twice;

    always_comb begin
        n_sh    = {r_rem[DW-1:0], r_n[NW-1]};
        n_diff  = n_sh - {1'b0, r_d};
        n_twice = {r_rem[DW-1:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_d   <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_n <= {r_n[NW-2:0], 1'b0};
                if (!n_diff[DW]) begin
                    r_rem <= n_diff;
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= n_sh;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
            end else if (n_twice >= {1'b0, r_d}) begin
                r_q <= r_q + 1'b1;
            end
        end
    end

    assign o_done = r_fin;
    assign o_quot = r_q;
endmodule
`default_nettype wire

FILE: rtl/core/bilinear_grid_interp_core.sv
`default_nettype none
// Query: from accept, each axis is searched (low end, high end, then binary search), then the
// two x and two y breakpoints and the four grid values are read, then three line steps (serial
// divide plus rounding) run on one shared divider, which sets the rate. Equal breakpoints
// skip the lines. Writes complete on accept; busy stays low. One query at a time; busy is high
// until the strobe cycle. Sync active-low reset clears control and counts (both 2); tables
// stay undefined until written. The receiver cannot stall: the strobe lasts one cycle.
module bilinear_grid_interp_core #(
    parameter int MAX_X_POINTS = 64,
    parameter int MAX_Y_POINTS = 64,
    parameter int VALUE_WIDTH  = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_opcode,
    input  wire logic [5:0]                  i_col_index,
    input  wire logic [5:0]                  i_row_index,
    input  wire logic signed [VALUE_WIDTH-1:0] i_write_value,
    input  wire logic signed [VALUE_WIDTH-1:0] i_query_a,
    input  wire logic signed [VALUE_WIDTH-1:0] i_query_b,
    input  wire logic                        i_cfg_we,
    input  wire logic [0:0]                  i_cfg_index,
    input  wire logic [bgi_pkg::CFG_WIDTH-1:0] i_cfg_data,
    output logic                             o_valid,
    output logic signed [VALUE_WIDTH-1:0]    o_interp_value,
    output logic [1:0]                       o_status
);
    localparam int XA = $clog2(MAX_X_POINTS);
    localparam int YA = $clog2(MAX_Y_POINTS);
    localparam int ZA = XA + YA;
    localparam int VW = VALUE_WIDTH;
    localparam int EW = VW + 1;
    localparam int PW = 2 * EW + 1;
    localparam int NW = PW + 1;
    localparam int CW = 11;

    bgi_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_xcnt, r_ycnt;
    logic signed [VW-1:0] r_a, r_b;
    logic [CW-1:0] r_lo, r_hi;
    logic [CW-1:0] r_i, r_j;
    logic [2:0]    r_zk;
    logic [1:0]    r_lk;
    logic signed [VW-1:0] r_x0, r_x1, r_y0, r_y1;
    logic signed [VW-1:0] r_z [4];
    logic signed [VW-1:0] r_w1, r_w2;
    logic signed [PW-1:0] r_p0, r_p1;
    logic          r_neg, r_sat, r_eq;
    logic signed [VW-1:0] r_res;
    logic [1:0]    r_stat;
    logic          r_valid;

    logic          x_we, y_we, z_we;
    logic [XA-1:0] x_ra;
    logic [YA-1:0] y_ra;
    logic [ZA-1:0] z_ra;
    logic [VW-1:0] x_rd, y_rd, z_rd;
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_q;
    logic [EW-1:0] div_den;

    logic [CW-1:0] mid;
    logic [CW-1:0] n_cfg;
    logic          accept;
    logic signed [VW-1:0] l_x0, l_x1, l_y0, l_y1, l_t;
    logic signed [EW-1:0] l_d0, l_d1, l_den;
    logic signed [NW-1:0] num;
    logic [NW-1:0] unum;
    logic [NW-1:0] lim;
    logic          over;
    logic signed [VW-1:0] lres;

    assign accept = start && !busy;
    assign mid    = (r_lo + r_hi) >> 1;

    always_comb begin
        n_cfg = CW'(i_cfg_data);
        if (n_cfg < CW'(2)) n_cfg = CW'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xcnt <= CW'(2);
            r_ycnt <= CW'(2);
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'(bgi_pkg::CFG_X_COUNT)) begin
                r_xcnt <= (n_cfg > CW'(MAX_X_POINTS)) ? CW'(MAX_X_POINTS) : n_cfg;
            end else begin
                r_ycnt <= (n_cfg > CW'(MAX_Y_POINTS)) ? CW'(MAX_Y_POINTS) : n_cfg;
            end
        end
    end

    assign x_we = accept && i_opcode == bgi_pkg::OP_WR_X && 32'(i_col_index) < MAX_X_POINTS;
    assign y_we = accept && i_opcode == bgi_pkg::OP_WR_Y && 32'(i_row_index) < MAX_Y_POINTS;
    assign z_we = accept && i_opcode == bgi_pkg::OP_WR_Z
                  && 32'(i_col_index) < MAX_X_POINTS && 32'(i_row_index) < MAX_Y_POINTS;

    bgi_ram #(.WIDTH(VW), .DEPTH(MAX_X_POINTS)) u_xram (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(XA'(i_col_index)),
        .i_wdata(i_write_value), .i_raddr(x_ra), .o_rdata(x_rd));
    bgi_ram #(.WIDTH(VW), .DEPTH(MAX_Y_POINTS)) u_yram (
        .i_clk(i_clk), .i_we(y_we), .i_waddr(YA'(i_row_index)),
        .i_wdata(i_write_value), .i_raddr(y_ra), .o_rdata(y_rd));
    bgi_ram #(.WIDTH(VW), .DEPTH(MAX_X_POINTS * MAX_Y_POINTS)) u_zram (
        .i_clk(i_clk), .i_we(z_we),
        .i_waddr({YA'(i_row_index), XA'(i_col_index)}),
        .i_wdata(i_write_value), .i_raddr(z_ra), .o_rdata(z_rd));

    bgi_div #(.NW(NW), .DW(EW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_q));

    // read addresses
    always_comb begin
        x_ra = '0;
        y_ra = '0;
        z_ra = '0;
        case (r_state)
            bgi_pkg::S_XLO_RD: x_ra = XA'(1);
            bgi_pkg::S_XLO_CHK: x_ra = XA'(r_xcnt - 1'b1);
            bgi_pkg::S_XBS_RD: x_ra = XA'(mid - 1'b1);
            bgi_pkg::S_YLO_RD: y_ra = YA'(1);
            bgi_pkg::S_YLO_CHK: y_ra = YA'(r_ycnt - 1'b1);
            bgi_pkg::S_YBS_RD: y_ra = YA'(mid - 1'b1);
            bgi_pkg::S_XE0_RD: x_ra = XA'(r_i);
            bgi_pkg::S_XE1_RD: x_ra = XA'(r_i + 1'b1);
            bgi_pkg::S_YE0_RD: y_ra = YA'(r_j);
            bgi_pkg::S_YE1_RD: y_ra = YA'(r_j + 1'b1);
            bgi_pkg::S_Z_RD:
                z_ra = {YA'(r_j + CW'(r_zk[1])), XA'(r_i + CW'(r_zk[0]))};
            default: ;
        endcase
    end

    // line operands for the current step
    always_comb begin
        l_x0 = r_x0;
        l_x1 = r_x1;
        l_t  = r_a;
        case (r_lk)
            2'd0: begin l_y0 = r_z[0]; l_y1 = r_z[1]; end
            2'd1: begin l_y0 = r_z[2]; l_y1 = r_z[3]; end
            default: begin
                l_y0 = r_w1; l_y1 = r_w2;
                l_x0 = r_y0; l_x1 = r_y1; l_t = r_b;
            end
        endcase
        l_d0  = EW'(l_t) - EW'(l_x1);
        l_d1  = EW'(l_t) - EW'(l_x0);
        l_den = EW'(l_x0) - EW'(l_x1);
        num   = NW'(r_p0) - NW'(r_p1);
        unum  = num[NW-1] ? NW'(-num) : NW'(num);
        lim   = r_neg ? (NW'(1) << (VW - 1)) : ((NW'(1) << (VW - 1)) - 1'b1);
        over  = div_q > lim;
        lres  = over ? VW'(lim) : VW'(div_q);
        if (r_neg) lres = -lres;
    end

    // products are registered in S_LIN_MUL; the divide is started from S_LIN_GO, the state after it
    assign div_start = r_state == bgi_pkg::S_LIN_GO;
    assign div_num   = unum;
    assign div_den   = l_den[EW-1] ? EW'(-l_den) : EW'(l_den);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bgi_pkg::S_IDLE:
                if (accept && i_opcode == bgi_pkg::OP_QUERY) n_state = bgi_pkg::S_XLO_RD;
            bgi_pkg::S_XLO_RD: n_state = bgi_pkg::S_XLO_CHK;
            bgi_pkg::S_XLO_CHK:
                n_state = (r_a <= $signed(x_rd)) ? bgi_pkg::S_YLO_RD : bgi_pkg::S_XHI_CHK;
            bgi_pkg::S_XHI_CHK:
                n_state = (r_a >= $signed(x_rd)) ? bgi_pkg::S_YLO_RD : bgi_pkg::S_XBS_RD;
            bgi_pkg::S_XBS_RD:
                n_state = (r_hi - r_lo == CW'(1)) ? bgi_pkg::S_YLO_RD : bgi_pkg::S_XBS_CHK;
            bgi_pkg::S_XBS_CHK: n_state = bgi_pkg::S_XBS_RD;
            bgi_pkg::S_YLO_RD: n_state = bgi_pkg::S_YLO_CHK;
            bgi_pkg::S_YLO_CHK:
                n_state = (r_b <= $signed(y_rd)) ? bgi_pkg::S_XE0_RD : bgi_pkg::S_YHI_CHK;
            bgi_pkg::S_YHI_CHK:
                n_state = (r_b >= $signed(y_rd)) ? bgi_pkg::S_XE0_RD : bgi_pkg::S_YBS_RD;
            bgi_pkg::S_YBS_RD:
                n_state = (r_hi - r_lo == CW'(1)) ? bgi_pkg::S_XE0_RD : bgi_pkg::S_YBS_CHK;
            bgi_pkg::S_YBS_CHK: n_state = bgi_pkg::S_YBS_RD;
            bgi_pkg::S_XE0_RD: n_state = bgi_pkg::S_XE1_RD;
            bgi_pkg::S_XE1_RD: n_state = bgi_pkg::S_YE0_RD;
            bgi_pkg::S_YE0_RD: n_state = bgi_pkg::S_YE1_RD;
            bgi_pkg::S_YE1_RD: n_state = bgi_pkg::S_Z_RD;
            bgi_pkg::S_Z_RD:   n_state = bgi_pkg::S_Z_CAP;
            bgi_pkg::S_Z_CAP:
                n_state = (r_zk == 3'd3) ? bgi_pkg::S_EQ_CHK : bgi_pkg::S_Z_RD;
            bgi_pkg::S_EQ_CHK:
                n_state = r_eq ? bgi_pkg::S_DONE : bgi_pkg::S_LIN_MUL;
            bgi_pkg::S_LIN_MUL: n_state = bgi_pkg::S_LIN_GO;
            bgi_pkg::S_LIN_GO:  n_state = bgi_pkg::S_LIN_DIV;
            bgi_pkg::S_LIN_DIV: if (div_done) n_state = bgi_pkg::S_LIN_END;
            bgi_pkg::S_LIN_END:
                n_state = (r_lk == 2'd2) ? bgi_pkg::S_DONE : bgi_pkg::S_LIN_MUL;
            bgi_pkg::S_DONE: n_state = bgi_pkg::S_IDLE;
            default: n_state = bgi_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy = r_state != bgi_pkg::S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgi_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= r_state == bgi_pkg::S_DONE;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            bgi_pkg::S_IDLE: begin
                r_a   <= i_query_a;
                r_b   <= i_query_b;
                r_i   <= '0;
                r_j   <= '0;
                r_sat <= 1'b0;
                r_zk  <= '0;
                r_lk  <= '0;
            end
            bgi_pkg::S_XLO_CHK: begin
                r_lo <= CW'(1);
                r_hi <= r_xcnt;
            end
            bgi_pkg::S_XHI_CHK:
                if (r_a >= $signed(x_rd)) r_i <= r_xcnt - CW'(2);
            bgi_pkg::S_XBS_RD:
                if (r_hi - r_lo == CW'(1)) r_i <= r_lo - 1'b1;
            bgi_pkg::S_XBS_CHK:
                if (r_a < $signed(x_rd)) r_hi <= mid; else r_lo <= mid;
            bgi_pkg::S_YLO_CHK: begin
                r_lo <= CW'(1);
                r_hi <= r_ycnt;
            end
            bgi_pkg::S_YHI_CHK:
                if (r_b >= $signed(y_rd)) r_j <= r_ycnt - CW'(2);
            bgi_pkg::S_YBS_RD:
                if (r_hi - r_lo == CW'(1)) r_j <= r_lo - 1'b1;
            bgi_pkg::S_YBS_CHK:
                if (r_b < $signed(y_rd)) r_hi <= mid; else r_lo <= mid;
            bgi_pkg::S_XE1_RD: r_x0 <= x_rd;
            bgi_pkg::S_YE0_RD: r_x1 <= x_rd;
            bgi_pkg::S_YE1_RD: r_y0 <= y_rd;
            bgi_pkg::S_Z_RD: if (r_zk == 3'd0) r_y1 <= y_rd;
            bgi_pkg::S_Z_CAP: begin
                r_z[r_zk[1:0]] <= z_rd;
                r_zk <= r_zk + 1'b1;
                r_eq <= (r_x0 == r_x1) || (r_y0 == r_y1);
            end
            bgi_pkg::S_LIN_MUL: begin
                r_p0  <= PW'(l_y0) * PW'(l_d0);
                r_p1  <= PW'(l_y1) * PW'(l_d1);
            end
            bgi_pkg::S_LIN_DIV:
                r_neg <= num[NW-1] != l_den[EW-1];
            bgi_pkg::S_LIN_END: begin
                if (over) r_sat <= 1'b1;
                case (r_lk)
                    2'd0: r_w1 <= lres;
                    2'd1: r_w2 <= lres;
                    default: r_res <= lres;
                endcase
                r_lk <= r_lk + 1'b1;
            end
            default: ;
        endcase
        if (r_state == bgi_pkg::S_DONE) begin
            if (r_eq) r_stat <= bgi_pkg::ST_EQUAL;
            else if (r_sat) r_stat <= bgi_pkg::ST_SAT;
            else r_stat <= bgi_pkg::ST_OK;
        end
    end

    assign o_valid        = r_valid;
    assign o_interp_value = r_eq ? '0 : r_res;
    assign o_status       = r_stat;

    a_no_start_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bgi_pkg::S_DONE |=> o_valid) else $error("missing strobe");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == bgi_pkg::S_LIN_DIV) else $error("stray divide");
endmodule
`default_nettype wire
